### sv/vpd_pkg.sv
// shared types, constants and tables for the vapor pressure deficit block
package vpd_pkg;

   localparam int FRAC_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH       = 4;

   // field widths
   localparam int TEMP_W = 15;
   localparam int HUM_W  = 14;
   localparam int DEF_W  = 15;

   // widths of the classified request
   localparam int MAG_W  = 15;
   localparam int PROD_W = 25;
   localparam int BASE_W = 16;
   localparam int COEF_W = 26;

   // tetens and unit constants
   localparam logic [10:0] TETENS_A_X100 = 11'd1727;
   localparam logic [14:0] TETENS_B_X100 = 15'd23730;
   localparam logic [6:0]  DEN_SCALE     = 7'd100;
   localparam logic [13:0] HUM_FULL      = 14'd10000;
   localparam logic [12:0] SVP0_X10K     = 13'd6108;
   localparam logic [32:0] LOG2E_Q32     = 33'd6196328019;
   localparam logic [31:0] LN2_Q32       = 32'd2977044472;

   // final scaling: divide by 2e6 as a shift by 7 and a divide by 15625
   localparam logic [19:0] ROUND_HALF    = 20'd1000000;
   localparam logic [13:0] OUT_DIV_ODD   = 14'd15625;
   localparam logic [18:0] OUT_DIV_RECIP = 19'd274877;
   localparam logic [14:0] OUT_MAX       = 15'd32767;

   typedef struct packed {
      logic              neg;
      logic [PROD_W-1:0] prod;
      logic [BASE_W-1:0] base;
      logic              zero;
      logic [COEF_W-1:0] coef;
   } item_type;

   // 2^(j/4) in q30
   function automatic logic [30:0] pow2_quarter(input logic [1:0] j);
      logic [30:0] val;
      unique case (j)
         2'd0: val = 31'd1073741824;
         2'd1: val = 31'd1276901417;
         2'd2: val = 31'd1518500250;
         2'd3: val = 31'd1805811301;
         default: val = 31'd1073741824;
      endcase
      return val;
   endfunction

endpackage

### sv/vpd_front.sv
// front end: takes requests and classifies them for the arithmetic pipeline
module vpd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [vpd_pkg::TEMP_W-1:0]  req_temp_centi_c,
   input  logic        [vpd_pkg::HUM_W-1:0]   req_humidity_centi_pct,
   output logic                               item_valid,
   input  logic                               item_ready,
   output vpd_pkg::item_type                  item
);

   logic                           valid_ff;
   vpd_pkg::item_type              item_ff;
   vpd_pkg::item_type              item_in;
   logic                           accept;
   logic [vpd_pkg::MAG_W-1:0]      mag;
   logic [25:0]                    prod_w;
   logic signed [16:0]             base_w;
   logic [vpd_pkg::HUM_W-1:0]      dh;

   assign req_ready  = !valid_ff || item_ready;
   assign accept     = req_valid && req_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      // magnitude of -16384 still fits as an unsigned 15 bit value
      mag     = req_temp_centi_c[vpd_pkg::TEMP_W-1] ?
                (~req_temp_centi_c + 15'd1) : req_temp_centi_c;
      prod_w  = 26'(mag) * 26'(vpd_pkg::TETENS_A_X100);
      base_w  = {{2{req_temp_centi_c[vpd_pkg::TEMP_W-1]}}, req_temp_centi_c}
                + $signed({2'b00, vpd_pkg::TETENS_B_X100});
      dh      = vpd_pkg::HUM_FULL - req_humidity_centi_pct;
      item_in.neg  = req_temp_centi_c[vpd_pkg::TEMP_W-1];
      item_in.prod = prod_w[vpd_pkg::PROD_W-1:0];
      item_in.base = base_w[vpd_pkg::BASE_W-1:0];
      item_in.zero = req_humidity_centi_pct >= vpd_pkg::HUM_FULL;
      item_in.coef = 26'(dh) * 26'(vpd_pkg::SVP0_X10K);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

### sv/vpd_fifo.sv
// short request queue between front end and arithmetic pipeline
module vpd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a pop");

endmodule

### sv/vpd_div.sv
// pipelined restoring divider, one quotient bit per stage
module vpd_div #(
   parameter int NUM_W  = 58,
   parameter int DEN_W  = 30,
   parameter int QUO_W  = 30,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [QUO_W];
   logic [DEN_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  bits_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic              v_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [QUO_W-1:0]  bits_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              take;

      if (i == 0) begin : g_first
         // top numerator bits are below the divisor since the quotient fits
         assign v_prev    = in_valid;
         assign rem_prev  = DEN_W'(in_num[NUM_W-1:QUO_W]);
         assign bits_prev = in_num[QUO_W-1:0];
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign bits_prev = bits_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign trial = {rem_prev, bits_prev[QUO_W-1]};
      assign take  = trial >= {1'b0, den_prev};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= v_prev;
         end
      end

      // numerator bits shift out at the top, quotient bits shift in below
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            bits_ff[i] <= {bits_prev[QUO_W-2:0], take};
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = bits_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

### sv/vpd_back.sv
// back end: exponent, tetens pressure, deficit scaling and result register
module vpd_back #(
   parameter int FRAC_BITS = vpd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  vpd_pkg::item_type               item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [vpd_pkg::DEF_W-1:0]       rsp_deficit_centi_kpa
);

   localparam int F      = FRAC_BITS;
   localparam int NUM_W  = 58;
   localparam int QUO_W  = F + 6;
   localparam int DEN_W  = 54 - F;
   localparam int DEN_SH = 32 - F;
   localparam int A_W    = F + 28;
   localparam int X_W    = 38;
   localparam logic [6:0] SH_BASE = 7'(F - 1);

   typedef struct packed {
      logic                       neg;
      logic                       zero;
      logic [vpd_pkg::COEF_W-1:0] coef;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   logic adv;
   logic rsp_valid_ff;
   logic [vpd_pkg::DEF_W-1:0] rsp_deficit_ff;

   assign adv                   = !rsp_valid_ff || rsp_ready;
   assign item_ready            = adv;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_deficit_centi_kpa = rsp_deficit_ff;

   // s0: numerator product and scaled divisor
   logic              s0_valid_ff;
   logic [NUM_W-1:0]  s0_mul_ff;
   logic [DEN_W-1:0]  s0_den_ff;
   side_type          s0_side_ff;
   side_type          s0_side_in;

   always_comb begin
      s0_side_in.neg  = item.neg;
      s0_side_in.zero = item.zero;
      s0_side_in.coef = item.coef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_mul_ff  <= NUM_W'(item.prod) * NUM_W'(vpd_pkg::LOG2E_Q32);
         s0_den_ff  <= DEN_W'(DEN_W'(item.base) * DEN_W'(vpd_pkg::DEN_SCALE)) << DEN_SH;
         s0_side_ff <= s0_side_in;
      end
   end

   // s1: round half up before the divide
   logic              s1_valid_ff;
   logic [NUM_W-1:0]  s1_num_ff;
   logic [DEN_W-1:0]  s1_den_ff;
   side_type          s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_num_ff  <= s0_mul_ff + NUM_W'(s0_den_ff >> 1);
         s1_den_ff  <= s0_den_ff;
         s1_side_ff <= s0_side_ff;
      end
   end

   // |y| in q(F) via the long divider
   logic              dv_valid;
   logic [QUO_W-1:0]  dv_quo;
   logic [SIDE_W-1:0] dv_side_bits;
   side_type          dv_side;

   vpd_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_num_ff),
      .in_den    (s1_den_ff),
      .in_side   (s1_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side_bits)
   );

   assign dv_side = dv_side_bits;

   // s2: split into integer exponent and fraction, fold the sign
   logic              s2_valid_ff;
   logic [1:0]        s2_j_ff;
   logic [F-3:0]      s2_g_ff;
   logic [6:0]        s2_sh_ff;
   side_type          s2_side_ff;
   logic [5:0]        ip;
   logic [F-1:0]      fr;
   logic [F-1:0]      f_in;
   logic [6:0]        s2_sh_in;

   always_comb begin
      ip   = dv_quo[QUO_W-1:F];
      fr   = dv_quo[F-1:0];
      f_in = dv_side.neg ? (F'(0) - fr) : fr;
      // shift is F - 1 - n with n the floor of y
      s2_sh_in = dv_side.neg ? (SH_BASE + 7'(ip) + 7'(fr != '0)) : (SH_BASE - 7'(ip));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_j_ff    <= f_in[F-1:F-2];
         s2_g_ff    <= f_in[F-3:0];
         s2_sh_ff   <= s2_sh_in;
         s2_side_ff <= dv_side;
      end
   end

   // s3: u = g * ln2
   logic              s3_valid_ff;
   logic [F-3:0]      s3_u_ff;
   logic [1:0]        s3_j_ff;
   logic [6:0]        s3_sh_ff;
   side_type          s3_side_ff;
   logic [F+29:0]     u_prod;

   assign u_prod = (F+30)'(s2_g_ff) * (F+30)'(vpd_pkg::LN2_Q32) + ((F+30)'(1) << 31);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_u_ff    <= u_prod[F+29:32];
         s3_j_ff    <= s2_j_ff;
         s3_sh_ff   <= s2_sh_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // horner steps for e^u, k from 6 down to 1, three stages each
   logic         st_valid [7];
   logic [F:0]   st_t     [7];
   logic [F-3:0] st_u     [7];
   logic [1:0]   st_j     [7];
   logic [6:0]   st_sh    [7];
   side_type     st_side  [7];

   assign st_valid[0] = s3_valid_ff;
   assign st_t[0]     = (F+1)'(1) << F;
   assign st_u[0]     = s3_u_ff;
   assign st_j[0]     = s3_j_ff;
   assign st_sh[0]    = s3_sh_ff;
   assign st_side[0]  = s3_side_ff;

   for (genvar h = 0; h < 6; h++) begin : g_horner
      localparam int K = 6 - h;
      localparam longint unsigned RECIP = (64'd1 << FRAC_BITS) / K;

      logic           a_valid_ff, b_valid_ff, c_valid_ff;
      logic [2*F-1:0] a_prod_ff;
      logic [F-1:0]   b_v_ff;
      logic [F-1:0]   b_q_ff;
      logic [F:0]     c_t_ff;
      logic [F-3:0]   a_u_ff, b_u_ff, c_u_ff;
      logic [1:0]     a_j_ff, b_j_ff, c_j_ff;
      logic [6:0]     a_sh_ff, b_sh_ff, c_sh_ff;
      side_type       a_side_ff, b_side_ff, c_side_ff;
      logic [2*F:0]   recip_prod;
      logic [F-1:0]   rem;
      logic [F-1:0]   q_in;

      assign recip_prod = (2*F+1)'(a_prod_ff[2*F-1:F]) * (2*F+1)'(RECIP);
      assign rem        = b_v_ff - F'(b_q_ff * F'(K));
      assign q_in       = (rem >= F'(K)) ? b_q_ff + 1'b1 : b_q_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff <= 1'b0;
            b_valid_ff <= 1'b0;
            c_valid_ff <= 1'b0;
         end else if (adv) begin
            a_valid_ff <= st_valid[h];
            b_valid_ff <= a_valid_ff;
            c_valid_ff <= b_valid_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            // u * t plus half of k in q(F)
            a_prod_ff <= (2*F)'(st_u[h]) * (2*F)'(st_t[h]) + ((2*F)'(K) << (F - 1));
            a_u_ff    <= st_u[h];
            a_j_ff    <= st_j[h];
            a_sh_ff   <= st_sh[h];
            a_side_ff <= st_side[h];
            // reciprocal estimate, low by at most one
            b_v_ff    <= a_prod_ff[2*F-1:F];
            b_q_ff    <= recip_prod[2*F-1:F];
            b_u_ff    <= a_u_ff;
            b_j_ff    <= a_j_ff;
            b_sh_ff   <= a_sh_ff;
            b_side_ff <= a_side_ff;
            c_t_ff    <= ((F+1)'(1) << F) + (F+1)'(q_in);
            c_u_ff    <= b_u_ff;
            c_j_ff    <= b_j_ff;
            c_sh_ff   <= b_sh_ff;
            c_side_ff <= b_side_ff;
         end
      end

      assign st_valid[h+1] = c_valid_ff;
      assign st_t[h+1]     = c_t_ff;
      assign st_u[h+1]     = c_u_ff;
      assign st_j[h+1]     = c_j_ff;
      assign st_sh[h+1]    = c_sh_ff;
      assign st_side[h+1]  = c_side_ff;
   end

   // s4: p = 2^(j/4) * e^u
   logic          s4_valid_ff;
   logic [F+1:0]  s4_p_ff;
   logic [6:0]    s4_sh_ff;
   side_type      s4_side_ff;
   logic [F+31:0] p_prod;

   assign p_prod = (F+32)'(vpd_pkg::pow2_quarter(st_j[6])) * (F+32)'(st_t[6])
                   + ((F+32)'(1) << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= st_valid[6];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_p_ff    <= p_prod[F+31:30];
         s4_sh_ff   <= st_sh[6];
         s4_side_ff <= st_side[6];
      end
   end

   // s5: scale by 0.6108 and by the dry fraction
   logic          s5_valid_ff;
   logic [A_W-1:0] s5_a_ff;
   logic [6:0]    s5_sh_ff;
   logic          s5_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_a_ff    <= A_W'(s4_p_ff) * A_W'(s4_side_ff.coef);
         s5_sh_ff   <= s4_sh_ff;
         s5_zero_ff <= s4_side_ff.zero;
      end
   end

   // s6: apply 2^n, keeping the round bit, add half and drop the power of two
   logic          s6_valid_ff;
   logic [31:0]   s6_w_ff;
   logic          s6_zero_ff;
   logic [A_W-1:0] a_shift;
   logic [X_W:0]  v_sum;

   assign a_shift = s5_a_ff >> s5_sh_ff;
   assign v_sum   = (X_W+1)'(a_shift[X_W-1:0]) + (X_W+1)'(vpd_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_w_ff    <= v_sum[X_W:7];
         s6_zero_ff <= s5_zero_ff;
      end
   end

   // s7: reciprocal estimate of w / 15625
   logic          s7_valid_ff;
   logic [18:0]   s7_q_ff;
   logic [31:0]   s7_w_ff;
   logic          s7_zero_ff;
   logic [50:0]   w_prod;

   assign w_prod = 51'(s6_w_ff) * 51'(vpd_pkg::OUT_DIV_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_q_ff    <= w_prod[50:32];
         s7_w_ff    <= s6_w_ff;
         s7_zero_ff <= s6_zero_ff;
      end
   end

   // correction, clamp and result register
   logic [31:0] w_rem;
   logic [19:0] q_fix;
   logic [vpd_pkg::DEF_W-1:0] res_in;

   always_comb begin
      w_rem = s7_w_ff - 32'(s7_q_ff) * 32'(vpd_pkg::OUT_DIV_ODD);
      q_fix = (w_rem >= 32'(vpd_pkg::OUT_DIV_ODD)) ? 20'(s7_q_ff) + 20'd1 : 20'(s7_q_ff);
      if (s7_zero_ff) begin
         res_in = '0;
      end else if (q_fix > 20'(vpd_pkg::OUT_MAX)) begin
         res_in = vpd_pkg::OUT_MAX;
      end else begin
         res_in = q_fix[vpd_pkg::DEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_deficit_ff <= res_in;
      end
   end

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (adv && s7_valid_ff) |=> rsp_valid_ff)
      else $error("finished item lost before the result register");

endmodule

### sv/vapor_pressure_deficit.sv
// top level of the tetens vapor pressure deficit block
//
// request channel: req_valid / req_ready with req_temp_centi_c (signed
// hundredths of a degree C) and req_humidity_centi_pct (hundredths of a
// percent). response channel: rsp_valid / rsp_ready with
// rsp_deficit_centi_kpa, the deficit in hundredths of a kPa, rounded to
// nearest, zero at or above 100 percent humidity, clamped at 32767.
// one response per request, in request order.
// throughput is one request per cycle while the response side does not stall;
// the pipeline is long mainly because of the one-bit-per-stage divider
// (FRAC_BITS + 6 stages) and the six three-stage horner steps of the
// exponential.
// a front register classifies each request and hands it to a four-entry
// queue; the arithmetic pipeline pulls from the queue and holds as a whole
// while rsp_valid is high and rsp_ready is low. requests keep flowing into
// the queue until it fills, then req_ready drops.
// synchronous reset empties the front register, the queue and the pipeline;
// there is no other state.
module vapor_pressure_deficit #(
   parameter int FRAC_BITS = vpd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [vpd_pkg::TEMP_W-1:0] req_temp_centi_c,
   input  logic        [vpd_pkg::HUM_W-1:0]  req_humidity_centi_pct,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic        [vpd_pkg::DEF_W-1:0]  rsp_deficit_centi_kpa
);

   localparam int ITEM_W = $bits(vpd_pkg::item_type);

   // front register to queue
   logic              fr_valid;
   logic              fr_ready;
   vpd_pkg::item_type fr_item;

   // queue to arithmetic pipeline
   logic              q_valid;
   logic              q_ready;
   logic [ITEM_W-1:0] q_data;
   vpd_pkg::item_type q_item;

   vpd_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_temp_centi_c       (req_temp_centi_c),
      .req_humidity_centi_pct (req_humidity_centi_pct),
      .item_valid             (fr_valid),
      .item_ready             (fr_ready),
      .item                   (fr_item)
   );

   // lets the front keep accepting while the pipeline is held
   vpd_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (vpd_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign q_item = q_data;

   // exponent, pressure and deficit pipeline with the result register
   vpd_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .item_valid            (q_valid),
      .item_ready            (q_ready),
      .item                  (q_item),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_deficit_centi_kpa (rsp_deficit_centi_kpa)
   );

endmodule

### bench/vapor_pressure_deficit_test.sv
// testbench for the tetens vapor pressure deficit block: directed and random requests
`timescale 1ns / 1ps

module vapor_pressure_deficit_test;

   localparam int FB = vpd_pkg::FRAC_BITS_DEFAULT;
   // pipeline latency plus margin for the queue and front register
   localparam int DRAIN_CYCLES = FB + 34 + 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [vpd_pkg::TEMP_W-1:0] req_temp_centi_c = '0;
   logic [vpd_pkg::HUM_W-1:0] req_humidity_centi_pct = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [vpd_pkg::DEF_W-1:0] rsp_deficit_centi_kpa;

   // deficits still owed by the block, oldest first
   logic [vpd_pkg::DEF_W-1:0] owed_deficits[$];
   int mismatches = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int dry_count = 0;      // requests at or above full humidity
   int wide_count = 0;     // requests outside the stated temperature range

   vapor_pressure_deficit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_temp_centi_c(req_temp_centi_c),
      .req_humidity_centi_pct(req_humidity_centi_pct),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_deficit_centi_kpa(rsp_deficit_centi_kpa)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // round half up division
   function automatic longint unsigned div_round(longint unsigned a, longint unsigned b);
      return (a + b / 2) / b;
   endfunction

   // expected deficit in hundredths of a kPa, bit exact fixed point tetens
   function automatic logic [vpd_pkg::DEF_W-1:0] deficit_of(
         logic signed [vpd_pkg::TEMP_W-1:0] t, logic [vpd_pkg::HUM_W-1:0] h);
      longint signed tc;
      longint unsigned one_q, mag, den, ymag, ip, fr, f, j, g, u, ex, p, a, b, bt, res;
      longint unsigned quarter;
      int n, s, k;
      one_q = 64'd1 << FB;
      tc = t;
      mag = (tc < 0) ? -tc : tc;
      den = (longint'(tc + 23730) * 64'd100) << (32 - FB);
      ymag = div_round(64'd1727 * mag * 64'd6196328019, den);
      ip = ymag >> FB;
      fr = ymag & (one_q - 1);
      // y = n + f with f in [0,1); negative temperatures borrow from n
      if (tc >= 0) begin
         n = int'(ip);
         f = fr;
      end else if (fr == 0) begin
         n = -int'(ip);
         f = 0;
      end else begin
         n = -int'(ip) - 1;
         f = one_q - fr;
      end
      j = (f >> (FB - 2)) & 64'd3;
      g = f & ((one_q >> 2) - 1);
      u = (g * 64'd2977044472 + (64'd1 << 31)) >> 32;
      ex = one_q;
      for (k = 6; k >= 1; k--) ex = one_q + div_round(u * ex, longint'(k) << FB);
      case (j)
         0: quarter = 64'd1073741824;
         1: quarter = 64'd1276901417;
         2: quarter = 64'd1518500250;
         default: quarter = 64'd1805811301;
      endcase
      p = (quarter * ex + (64'd1 << 29)) >> 30;
      res = 0;
      if (h < 14'd10000) begin
         a = p * (64'd6108 * (64'd10000 - h));
         s = FB - n;
         if (s < 1) begin
            res = 32767;
         end else if (s < 60) begin
            b = a >> s;
            bt = (a >> (s - 1)) & 64'd1;
            res = (2 * b + 64'd1000000 + bt) / 64'd2000000;
            if (res > 32767) res = 32767;
         end
      end
      return res[vpd_pkg::DEF_W-1:0];
   endfunction

   // send one request; valid stays high across back-to-back requests
   task automatic send_request(logic signed [vpd_pkg::TEMP_W-1:0] t,
                               logic [vpd_pkg::HUM_W-1:0] h);
      int gap;
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temp_centi_c <= t;
      req_humidity_centi_pct <= h;
      do @(posedge clock); while (!req_ready);
      owed_deficits.push_back(deficit_of(t, h));
      requests_sent++;
      if (h >= 14'd10000) dry_count++;
      if (t < -4000 || t > 12500) wide_count++;
   endtask

   // hold off until the block has answered everything
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (owed_deficits.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, check each accepted response in order
   initial begin
      int stall;
      logic [vpd_pkg::DEF_W-1:0] want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         responses_seen++;
         if (owed_deficits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: deficit %0d", rsp_deficit_centi_kpa);
         end else begin
            want = owed_deficits.pop_front();
            if (rsp_deficit_centi_kpa !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("deficit mismatch: expected %0d, got %0d", want,
                           rsp_deficit_centi_kpa);
            end
         end
      end
   end

   // corners: field extremes, full humidity, out-of-range temperatures
   task automatic test_corners();
      send_request(15'sd0, 14'd0);
      send_request(-15'sd4000, 14'd0);
      send_request(15'sd12500, 14'd0);
      send_request(15'sd12500, 14'd12500);
      send_request(-15'sd16384, 14'd0);
      send_request(15'sd16383, 14'd0);
      send_request(15'sd16383, 14'd16383);
      send_request(-15'sd16384, 14'd16383);
      send_request(15'sd2500, 14'd9999);
      send_request(15'sd2500, 14'd10000);
      send_request(15'sd2500, 14'd10001);
      send_request(15'sd2500, 14'd5000);
      send_request(-15'sd1, 14'd1);
      send_request(15'sd1, 14'd1);
      send_request(-15'sd2000, 14'd9999);
      send_request(15'sd10000, 14'd1);
      send_request(15'sd10922, 14'd5461);
      send_request(-15'sd5462, 14'd10922);
   endtask

   // random requests, mostly in the stated range, some over the full fields
   task automatic test_random(int count);
      int i;
      logic signed [vpd_pkg::TEMP_W-1:0] t;
      logic [vpd_pkg::HUM_W-1:0] h;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 8) begin
            t = vpd_pkg::TEMP_W'($urandom_range(0, 16500) - 4000);
            h = vpd_pkg::HUM_W'($urandom_range(0, 12500));
         end else begin
            t = vpd_pkg::TEMP_W'($urandom);
            h = vpd_pkg::HUM_W'($urandom);
         end
         send_request(t, h);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      wait_drained();
      test_random(750);
      wait_drained();
      test_random(750);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests, %0d responses checked", requests_sent, responses_seen);
      $display("%0d at full humidity or above, %0d outside the rated temperatures",
               dry_count, wide_count);
      if (mismatches == 0 && owed_deficits.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, owed_deficits.size());
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
sv/vpd_pkg.sv
sv/vpd_front.sv
sv/vpd_fifo.sv
sv/vpd_div.sv
sv/vpd_back.sv
sv/vapor_pressure_deficit.sv
bench/vapor_pressure_deficit_test.sv
